// File: hw/rtl/sorted_timer_queue_top_defines.svh
`ifndef SORTED_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held
`define STQ_CHECK(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define STQ_CHECK_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/stq_pkg.sv
package stq_pkg;

    localparam int SLOT_W = 7;
    localparam int TIME_W = 16;

    localparam logic [TIME_W-1:0] REBASE_TIME = 16'd32000;
    localparam logic [TIME_W-1:0] MAX_DELAY   = 16'd32000;
    localparam logic [TIME_W-1:0] NO_JOB_DUE  = 16'hFFFF;
    localparam logic [14:0]       THR_RESET   = 15'd100;

    localparam logic [1:0] OP_TIMED   = 2'd0;
    localparam logic [1:0] OP_BOUNDED = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_FLUSH   = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DUE  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_FULL  = 3'd1;
    localparam logic [2:0] ST_SHORT_FULL = 3'd2;
    localparam logic [2:0] ST_LONG_FULL  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_NO_SLOT    = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INS    = 2'd1,
        CELL_POP    = 2'd2,
        CELL_REBASE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic   full;
        logic   nonempty;
        logic   two;
        entry_t head;
        entry_t second;
    } q_stat_t;

endpackage

// File: hw/rtl/stq_cell.sv
module stq_cell (
    input  logic             aclk,
    input  stq_pkg::cell_op_t op,
    input  stq_pkg::entry_t  new_e,
    input  stq_pkg::entry_t  left_e,
    input  logic             left_gt,
    input  stq_pkg::entry_t  right_e,
    input  logic             occ,
    output stq_pkg::entry_t  e,
    output logic             gt
);
    import stq_pkg::*;

    entry_t e_reg;
    entry_t e_next;

    // an empty cell ranks above any new entry, so an insert due no earlier than every entry lands at the tail
    assign gt = !occ || (e_reg.due > new_e.due);
    assign e  = e_reg;

    always_comb begin
        e_next = e_reg;
        case (op)
            CELL_INS: begin
                if (gt) begin
                    e_next = left_gt ? left_e : new_e;
                end
            end
            CELL_POP:    e_next = right_e;
            CELL_REBASE: e_next.due = e_reg.due - REBASE_TIME;
            default:     e_next = e_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next;
    end

endmodule

// File: hw/rtl/stq_queue.sv
module stq_queue #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stq_pkg::cell_op_t op,
    input  stq_pkg::entry_t   new_e,
    output stq_pkg::q_stat_t  stat
);
    import stq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    entry_t        e   [DEPTH];
    logic          gt  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            entry_t left_e;
            logic   left_gt;
            entry_t right_e;
            if (i == 0) begin : g_first
                assign left_e  = new_e;
                assign left_gt = 1'b0;
            end else begin : g_mid
                assign left_e  = e[i-1];
                assign left_gt = gt[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_e = e[i];
            end else begin : g_inner
                assign right_e = e[i+1];
            end
            stq_cell u_cell (
                .aclk    (aclk),
                .op      (op),
                .new_e   (new_e),
                .left_e  (left_e),
                .left_gt (left_gt),
                .right_e (right_e),
                .occ     (CW'(i) < count_reg),
                .e       (e[i]),
                .gt      (gt[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        case (op)
            CELL_INS: count_next = count_reg + 1'b1;
            CELL_POP: begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign stat.full     = count_reg >= CW'(DEPTH - 1);
    assign stat.nonempty = count_reg != '0;
    assign stat.two      = count_reg > CW'(1);
    assign stat.head     = e[0];
    assign stat.second   = e[1];

endmodule

// File: hw/rtl/stq_free.sv
module stq_free #(
    parameter int SLOTS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic                       rel,
    input  logic [stq_pkg::SLOT_W-1:0] rel_slot,
    output logic [stq_pkg::SLOT_W-1:0] head,
    output logic                       empty
);
    import stq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOT_W-1:0] links [SLOTS];
    logic [SLOTS-1:0]  lv_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] rd_reg;
    logic              rv_reg;
    logic [SLOT_W-1:0] link_of_head;

    // a link never written carries no valid bit and is taken to be the following slot
    assign link_of_head = rv_reg ? rd_reg : head_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (rel) begin
            links[rel_slot[IW-1:0]] <= head_reg;
        end
        rd_reg <= links[head_reg[IW-1:0]];
        rv_reg <= lv_reg[head_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg   <= '0;
            head_reg <= '0;
        end else begin
            if (rel) begin
                lv_reg[rel_slot[IW-1:0]] <= 1'b1;
                head_reg                 <= rel_slot;
            end else if (take) begin
                head_reg <= link_of_head;
            end
        end
    end

    assign head  = head_reg;
    assign empty = head_reg >= SLOT_W'(SLOTS);

endmodule

// File: hw/rtl/sorted_timer_queue_top.sv
// Timer queue with sorted short and long queues, an unsorted zero-delay queue and a
// LIFO free list of job slots. Each queue is a row of cells: an insert shifts all the
// later entries up one place at once, and an expiry or flush pops one job per cycle
// off the head while the result register is free. An insert is accepted, then decoded
// and committed; a tick advances the time, checks whether any job can be due and, if
// one can, scans the short and then the long queue, popping each due job until it
// finds the first job that is not yet due; a flush pops each job of the zero queue, or
// emits one empty word if it is empty. One result word leaves per cycle unless
// m_tready holds it back. The slot links sit in a memory with a registered read of
// the free-list head, which is why an insert decodes before it commits. No clearing
// pass is needed after reset: the links carry valid bits.
`include "sorted_timer_queue_top_defines.svh"

module sorted_timer_queue_top #(
    parameter int SLOTS       = 64,
    parameter int SHORT_DEPTH = 16,
    parameter int LONG_DEPTH  = 32,
    parameter int ZERO_DEPTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] delay
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] job_slot, [8:6] status, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data   // short_threshold
);
    import stq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TIMED = 8'b0000_0010,
        S_BOUND = 8'b0000_0100,
        S_TICK  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_SHORT = 8'b0010_0000,
        S_LONG  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [14:0]       thr_reg;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [TIME_W-1:0] nd_reg, nd_next;
    logic [15:0]       delay_reg;
    logic              any_reg, any_next;

    logic              mv_reg;
    logic [5:0]        mslot_reg;
    logic [1:0]        mkind_reg;
    logic [2:0]        mstat_reg;
    logic              mlast_reg;

    logic              out_free;
    logic              out_load;
    logic [SLOT_W-1:0] out_slot;
    logic [1:0]        out_kind;
    logic [2:0]        out_status;
    logic              out_last;

    cell_op_t          sop, lop, zop;
    entry_t            new_e;
    q_stat_t           sst, lst, zst;

    logic              fl_take, fl_rel, fl_empty;
    logic [SLOT_W-1:0] fl_head;

    logic [15:0]       d_eff;
    logic              use_short;
    logic [TIME_W-1:0] due;
    logic [2:0]        ins_status;
    logic [TIME_W-1:0] t_inc;

    stq_queue #(.DEPTH(SHORT_DEPTH)) u_short (
        .aclk(aclk), .aresetn(aresetn), .op(sop), .new_e(new_e), .stat(sst)
    );
    stq_queue #(.DEPTH(LONG_DEPTH)) u_long (
        .aclk(aclk), .aresetn(aresetn), .op(lop), .new_e(new_e), .stat(lst)
    );
    stq_queue #(.DEPTH(ZERO_DEPTH)) u_zero (
        .aclk(aclk), .aresetn(aresetn), .op(zop), .new_e(new_e), .stat(zst)
    );
    stq_free #(.SLOTS(SLOTS)) u_free (
        .aclk(aclk), .aresetn(aresetn), .take(fl_take), .rel(fl_rel),
        .rel_slot(out_slot), .head(fl_head), .empty(fl_empty)
    );

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free  = !mv_reg || m_tready;

    // timed insert decode; a zero delay counts as one tick
    assign d_eff     = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    assign use_short = d_eff < {1'b0, thr_reg};
    assign due       = time_reg + d_eff;
    assign t_inc     = time_reg + 1'b1;

    always_comb begin
        if (d_eff > MAX_DELAY) begin
            ins_status = ST_TOO_LONG;
        end else if (use_short && sst.full) begin
            ins_status = ST_SHORT_FULL;
        end else if (!use_short && lst.full) begin
            ins_status = ST_LONG_FULL;
        end else if (fl_empty) begin
            ins_status = ST_NO_SLOT;
        end else begin
            ins_status = ST_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        time_next  = time_reg;
        nd_next    = nd_reg;
        any_next   = any_reg;
        out_load   = 1'b0;
        out_slot   = '0;
        out_kind   = KIND_NONE;
        out_status = ST_OK;
        out_last   = 1'b1;
        sop        = CELL_HOLD;
        lop        = CELL_HOLD;
        zop        = CELL_HOLD;
        new_e.due  = due;
        new_e.slot = fl_head;
        fl_take    = 1'b0;
        fl_rel     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        OP_TIMED:   state_next = S_TIMED;
                        OP_BOUNDED: state_next = S_BOUND;
                        OP_TICK:    state_next = S_TICK;
                        OP_FLUSH:   state_next = S_FLUSH;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_TIMED: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_ACK;
                    out_status = ins_status;
                    if (ins_status == ST_OK) begin
                        out_slot = fl_head;
                        fl_take  = 1'b1;
                        if (use_short) begin
                            sop = CELL_INS;
                        end else begin
                            lop = CELL_INS;
                        end
                        if (due < nd_reg) begin
                            nd_next = due;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_BOUND: begin
                new_e.due = '0;
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_ACK;
                    if (zst.full) begin
                        out_status = ST_ZERO_FULL;
                    end else if (fl_empty) begin
                        out_status = ST_NO_SLOT;
                    end else begin
                        out_slot = fl_head;
                        fl_take  = 1'b1;
                        zop      = CELL_INS;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                any_next = 1'b0;
                if (t_inc == REBASE_TIME) begin
                    time_next = '0;
                    nd_next   = nd_reg - REBASE_TIME;
                    sop       = CELL_REBASE;
                    lop       = CELL_REBASE;
                end else begin
                    time_next = t_inc;
                end
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (nd_reg <= time_reg) begin
                    nd_next    = NO_JOB_DUE;
                    state_next = S_SHORT;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHORT: begin
                if (sst.nonempty && sst.head.due <= time_reg) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_kind = KIND_DUE;
                        out_slot = sst.head.slot;
                        out_last = !((sst.two && sst.second.due <= time_reg) ||
                                     (lst.nonempty && lst.head.due <= time_reg));
                        fl_rel   = 1'b1;
                        sop      = CELL_POP;
                        any_next = 1'b1;
                    end
                end else begin
                    if (sst.nonempty) begin
                        nd_next = sst.head.due;
                    end
                    state_next = S_LONG;
                end
            end
            S_LONG: begin
                if (lst.nonempty && lst.head.due <= time_reg) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_kind = KIND_DUE;
                        out_slot = lst.head.slot;
                        out_last = !(lst.two && lst.second.due <= time_reg);
                        fl_rel   = 1'b1;
                        lop      = CELL_POP;
                        any_next = 1'b1;
                    end
                end else begin
                    if (lst.nonempty && lst.head.due < nd_reg) begin
                        nd_next = lst.head.due;
                    end
                    if (any_reg) begin
                        state_next = S_IDLE;
                    end else if (out_free) begin
                        // nothing emitted by this tick
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (zst.nonempty) begin
                        out_kind = KIND_DUE;
                        out_slot = zst.head.slot;
                        out_last = !zst.two;
                        fl_rel   = 1'b1;
                        zop      = CELL_POP;
                        if (!zst.two) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg   <= THR_RESET;
            time_reg  <= '0;
            nd_reg    <= NO_JOB_DUE;
            any_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            time_reg  <= time_next;
            nd_reg    <= nd_next;
            any_reg   <= any_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // hold the word until taken
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            delay_reg <= s_tdata;
        end
        if (out_load) begin
            mslot_reg <= out_slot[5:0];
            mkind_reg <= out_kind;
            mstat_reg <= out_status;
            mlast_reg <= out_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, mstat_reg, mslot_reg};
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

    `STQ_CHECK(a_take_nonempty, fl_take, !fl_empty, "slot taken from empty free list")
    `STQ_CHECK(a_short_room, sop == CELL_INS, !sst.full, "insert into full short queue")
    `STQ_CHECK(a_flush_has_job, fl_rel && state_reg == S_FLUSH, zst.nonempty,
               "flush released a slot from an empty zero queue")
    `STQ_CHECK_NEXT(a_rel_head, fl_rel, fl_head == $past(out_slot),
                    "released slot did not become free-list head")

endmodule
